>>> hw/rtl/iaid_pkg.sv
package iaid_pkg;

  localparam int ELEM_W = 32;
  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int ST_W   = 3;

  typedef logic signed [ELEM_W-1:0] elem_t;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
  localparam logic [ST_W-1:0] ST_BADIDX = 3'd3;
  localparam logic [ST_W-1:0] ST_BADCMD = 3'd4;

endpackage

>>> hw/rtl/iaid_ram.sv
module iaid_ram
  import iaid_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  elem_t         wdata,
  input  logic [AW-1:0] raddr,
  output elem_t         rdata
);

  elem_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/indexed_array_insert_delete_unit.sv
// Single-result items (clear, append, errors, insert at the end, delete of the last element):
// result in the cycle after accept, busy stays low, a new item can be taken every cycle.
// Dump: busy while reading, count results on consecutive cycles, each via the RAM read and output registers.
// Insert below the end: busy while the tail shifts up, then the new value is written; delete: busy while
// the tail shifts down; one element move per cycle through the element RAM, result in the cycle busy falls.
// Synchronous reset empties the list (count zero), RAM not cleared; the receiver cannot stall.
module indexed_array_insert_delete_unit
  import iaid_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] in_command,
  input  elem_t            in_value,
  input  logic [POS_W-1:0] in_position,
  output logic             out_valid,
  output elem_t            out_element,
  output logic [ST_W-1:0]  out_status,
  output logic             out_last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUMP,
    S_UP,
    S_INS,
    S_DN
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  elem_t           val_r, val_nxt;
  logic            ov_r, ov_nxt;
  elem_t           oe_r, oe_nxt;
  logic [ST_W-1:0] os_r, os_nxt;
  logic            ol_r, ol_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  elem_t           wdata;
  elem_t           rdata;

  logic [CW-1:0]    idx_inc, idx_dec, cnt_dec;
  logic [POS_W-1:0] cnt_ext;
  logic             full, empty;

  iaid_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_nxt[AW-1:0]),
    .rdata (rdata)
  );

  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;
  assign cnt_dec = count_r - 1'b1;
  assign cnt_ext = POS_W'(count_r);
  assign full    = (count_r == CAP_C);
  assign empty   = (count_r == '0);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    ov_nxt    = 1'b0;
    oe_nxt    = '0;
    os_nxt    = ST_OK;
    ol_nxt    = 1'b1;
    we        = 1'b0;
    waddr     = count_r[AW-1:0];
    wdata     = in_value;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ov_nxt = 1'b1;
          case (in_command)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_APPEND: begin
              if (full) begin
                os_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                os_nxt = ST_EMPTY;
              end else begin
                ov_nxt    = 1'b0;
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            CMD_INSERT: begin
              if (full) begin
                os_nxt = ST_FULL;
              end else if (in_position > cnt_ext) begin
                os_nxt = ST_BADIDX;
              end else if (in_position == cnt_ext) begin
                // insert at the end: plain append
                we        = 1'b1;
                count_nxt = count_r + 1'b1;
              end else begin
                ov_nxt    = 1'b0;
                val_nxt   = in_value;
                pos_nxt   = CW'(in_position);
                idx_nxt   = cnt_dec;
                state_nxt = S_UP;
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                os_nxt = ST_EMPTY;
              end else if (in_position >= cnt_ext) begin
                os_nxt = ST_BADIDX;
              end else if (in_position == cnt_ext - 1'b1) begin
                count_nxt = cnt_dec;
              end else begin
                ov_nxt    = 1'b0;
                idx_nxt   = CW'(in_position) + 1'b1;
                state_nxt = S_DN;
              end
            end
            default: begin
              os_nxt = ST_BADCMD;
            end
          endcase
        end
      end
      S_DUMP: begin
        // rdata holds element idx_r
        ov_nxt = 1'b1;
        oe_nxt = rdata;
        ol_nxt = (idx_r == cnt_dec);
        if (idx_r == cnt_dec) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_UP: begin
        // walk down from the top; reads stay below the write address
        we    = 1'b1;
        waddr = idx_inc[AW-1:0];
        wdata = rdata;
        if (idx_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          idx_nxt = idx_dec;
        end
      end
      S_INS: begin
        we        = 1'b1;
        waddr     = pos_r[AW-1:0];
        wdata     = val_r;
        count_nxt = count_r + 1'b1;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DN: begin
        we    = 1'b1;
        waddr = idx_dec[AW-1:0];
        wdata = rdata;
        if (idx_r == cnt_dec) begin
          count_nxt = cnt_dec;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    oe_r  <= oe_nxt;
    os_r  <= os_nxt;
    ol_r  <= ol_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = ov_r;
  assign out_element = oe_r;
  assign out_status  = os_r;
  assign out_last    = ol_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("count above capacity");

  a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_element == '0)
    else $error("error result carries an element");

  a_mid_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while idle");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_CLEAR |=>
      out_valid && out_last && out_status == ST_OK && count_r == '0)
    else $error("clear did not empty the list");

endmodule

>>> tb/testbench.sv
module testbench;
  import iaid_pkg::*;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS  = 100;

  // command codes with no operation behind them
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    elem_t           element;
    logic [ST_W-1:0] status;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    elem_t            val;
    logic [POS_W-1:0] pos;
    logic             typed;
    logic [ST_W-1:0]  st;
  } stim_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [CMD_W-1:0] in_command;
  elem_t            in_value;
  logic [POS_W-1:0] in_position;
  logic             out_valid;
  elem_t            out_element;
  logic [ST_W-1:0]  out_status;
  logic             out_last;

  indexed_array_insert_delete_unit #(.CAPACITY(DEPTH)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_command  (in_command),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_element (out_element),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // list contents as the block should hold them
  elem_t   list_vals [DEPTH];
  int      list_len;
  result_t item_results [$];
  result_t pending_results [$];
  result_t got, want;
  int      errors;
  int      cycles;

  // directed items; st is filled in where the outcome is plain
  stim_t directed [25] = '{
    '{CMD_DUMP,   32'sh0,        7'd0,   1'b1, ST_EMPTY},
    '{CMD_DELETE, 32'sh0,        7'd0,   1'b1, ST_EMPTY},
    '{CMD_DELETE, 32'sh0,        7'd127, 1'b1, ST_EMPTY},
    '{CMD_INSERT, 32'sh5,        7'd1,   1'b1, ST_BADIDX},
    '{CMD_INSERT, 32'sh7fffffff, 7'd0,   1'b1, ST_OK},
    '{CMD_APPEND, 32'sh80000000, 7'd0,   1'b1, ST_OK},
    '{CMD_APPEND, 32'shffffffff, 7'd127, 1'b1, ST_OK},
    '{CMD_APPEND, 32'sh0,        7'd0,   1'b1, ST_OK},
    '{CMD_INSERT, 32'sh12345678, 7'd2,   1'b0, ST_OK},
    '{CMD_INSERT, 32'sha5a5a5a5, 7'd0,   1'b0, ST_OK},
    '{CMD_INSERT, 32'sh5a5a5a5a, 7'd6,   1'b0, ST_OK},
    '{CMD_INSERT, 32'sh1,        7'd127, 1'b1, ST_BADIDX},
    '{CMD_DUMP,   32'sh0,        7'd0,   1'b0, ST_OK},
    '{CMD_DELETE, 32'sh0,        7'd0,   1'b0, ST_OK},
    '{CMD_DELETE, 32'sh0,        7'd5,   1'b0, ST_OK},
    '{CMD_DELETE, 32'sh0,        7'd5,   1'b1, ST_BADIDX},
    '{CMD_DELETE, 32'sh0,        7'd127, 1'b1, ST_BADIDX},
    '{CMD_RSVD5,  32'sh0,        7'd0,   1'b1, ST_BADCMD},
    '{CMD_RSVD6,  32'shffffffff, 7'd127, 1'b1, ST_BADCMD},
    '{CMD_RSVD7,  32'sh7fffffff, 7'd64,  1'b1, ST_BADCMD},
    '{CMD_DUMP,   32'sh0,        7'd0,   1'b0, ST_OK},
    '{CMD_CLEAR,  32'sh0,        7'd0,   1'b1, ST_OK},
    '{CMD_DUMP,   32'sh0,        7'd0,   1'b1, ST_EMPTY},
    '{CMD_APPEND, 32'sh7fffffff, 7'd0,   1'b1, ST_OK},
    '{CMD_DUMP,   32'sh0,        7'd0,   1'b0, ST_OK}
  };

  function automatic result_t rslt(elem_t e, logic [ST_W-1:0] s, logic l);
    result_t r;
    r.element = e;
    r.status  = s;
    r.last    = l;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS)
      $display("MISMATCH cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // updates the list and leaves the results of one item in item_results
  task automatic apply_list_cmd(input logic [CMD_W-1:0] cmd, input elem_t val,
                                input logic [POS_W-1:0] pos);
    int i;
    item_results.delete();
    case (cmd)
      CMD_CLEAR: begin
        list_len = 0;
        item_results.push_back(rslt(0, ST_OK, 1'b1));
      end
      CMD_APPEND: begin
        if (list_len >= DEPTH) begin
          item_results.push_back(rslt(0, ST_FULL, 1'b1));
        end else begin
          list_vals[list_len] = val;
          list_len++;
          item_results.push_back(rslt(0, ST_OK, 1'b1));
        end
      end
      CMD_DUMP: begin
        if (list_len == 0)
          item_results.push_back(rslt(0, ST_EMPTY, 1'b1));
        else
          for (i = 0; i < list_len; i++)
            item_results.push_back(rslt(list_vals[i], ST_OK, i == list_len - 1));
      end
      CMD_INSERT: begin
        // full wins over a bad index
        if (list_len >= DEPTH) begin
          item_results.push_back(rslt(0, ST_FULL, 1'b1));
        end else if (int'(pos) > list_len) begin
          item_results.push_back(rslt(0, ST_BADIDX, 1'b1));
        end else begin
          for (i = list_len; i > int'(pos); i--)
            list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_len++;
          item_results.push_back(rslt(0, ST_OK, 1'b1));
        end
      end
      CMD_DELETE: begin
        if (list_len == 0) begin
          item_results.push_back(rslt(0, ST_EMPTY, 1'b1));
        end else if (int'(pos) >= list_len) begin
          item_results.push_back(rslt(0, ST_BADIDX, 1'b1));
        end else begin
          for (i = int'(pos); i + 1 < list_len; i++)
            list_vals[i] = list_vals[i+1];
          list_len--;
          item_results.push_back(rslt(0, ST_OK, 1'b1));
        end
      end
      default: item_results.push_back(rslt(0, ST_BADCMD, 1'b1));
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_item(input logic [CMD_W-1:0] cmd, input elem_t val,
                           input logic [POS_W-1:0] pos, input logic typed,
                           input logic [ST_W-1:0] st, input bit may_idle);
    if (may_idle && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start       <= 1'b1;
    in_command  <= cmd;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (busy);
    apply_list_cmd(cmd, val, pos);
    if (typed)
      pending_results.push_back(rslt(0, st, 1'b1));
    else
      foreach (item_results[i]) pending_results.push_back(item_results[i]);
    @(negedge clk);
  endtask

  task automatic random_item(input int del_pct, input bit may_idle);
    int               r;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    elem_t            val;
    r = $urandom_range(99);
    if (r < 3) begin
      cmd = CMD_CLEAR;
    end else if (r < 8) begin
      case ($urandom_range(2))
        0:       cmd = CMD_RSVD5;
        1:       cmd = CMD_RSVD6;
        default: cmd = CMD_RSVD7;
      endcase
    end else if (r < 15) begin
      cmd = CMD_DUMP;
    end else if (r < 15 + (85 - del_pct) / 2) begin
      cmd = CMD_APPEND;
    end else if (r < 100 - del_pct) begin
      cmd = CMD_INSERT;
    end else begin
      cmd = CMD_DELETE;
    end
    r = $urandom_range(99);
    if (r < 10)
      pos = POS_W'($urandom_range(127));
    else if (r < 20)
      // just past the valid range
      pos = POS_W'((cmd == CMD_INSERT) ? list_len + 1 : list_len);
    else if (cmd == CMD_DELETE && list_len > 0)
      pos = POS_W'($urandom_range(list_len - 1));
    else
      pos = POS_W'($urandom_range(list_len));
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0:       val = 32'sh80000000;
        1:       val = 32'sh7fffffff;
        2:       val = 32'sh0;
        default: val = 32'shffffffff;
      endcase
    end else begin
      val = $urandom;
    end
    send_item(cmd, val, pos, 1'b0, ST_OK, may_idle);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      got = rslt(out_element, out_status, out_last);
      if (out_valid !== 1'b1) begin
        report_mismatch("out_valid unknown");
      end else if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item: element %0d status %0d last %0d",
                                  got.element, got.status, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.element !== want.element)
          report_mismatch($sformatf("element %0d, expected %0d", got.element, want.element));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_command  = CMD_CLEAR;
    in_value    = '0;
    in_position = '0;
    errors      = 0;
    cycles      = 0;
    list_len    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].val, directed[i].pos,
                directed[i].typed, directed[i].st, 1'b1);

    repeat (110) random_item(28, 1'b1);
    wait_results_drained();

    // fill to capacity with no gaps, then hit the full and edge cases
    send_item(CMD_CLEAR, 32'sh0, 7'd0, 1'b1, ST_OK, 1'b0);
    while (list_len < DEPTH) begin
      if ($urandom_range(1))
        send_item(CMD_APPEND, $urandom, 7'd0, 1'b0, ST_OK, 1'b0);
      else
        send_item(CMD_INSERT, $urandom, POS_W'($urandom_range(list_len)), 1'b0, ST_OK,
                  1'b0);
    end
    send_item(CMD_APPEND, 32'sh1,        7'd0,   1'b1, ST_FULL, 1'b0);
    send_item(CMD_INSERT, 32'sh2,        7'd0,   1'b1, ST_FULL, 1'b0);
    send_item(CMD_INSERT, 32'sh3,        7'd127, 1'b1, ST_FULL, 1'b0);
    send_item(CMD_DUMP,   32'sh0,        7'd0,   1'b0, ST_OK,   1'b0);
    send_item(CMD_DELETE, 32'sh0,        7'd64,  1'b1, ST_BADIDX, 1'b0);
    send_item(CMD_DELETE, 32'sh0,        7'd0,   1'b0, ST_OK,   1'b0);

    repeat (60) random_item(55, 1'b1);
    send_item(CMD_DUMP, 32'sh0, 7'd0, 1'b0, ST_OK, 1'b1);

    wait_results_drained();
    repeat (DEPTH + 8) @(negedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
